@@ hw/rtl/csft_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csft_pkg
// shared types, fixed-point constants and helpers of the swing foot trajectory
// ----------------------------------------------------------------------------
package csft_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_STEP_HEIGHT    = 2'd0;
    localparam logic [1:0] REG_INV_SWING_TIME = 2'd1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    // fixed-point constants
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [32:0] INV_PI_Q16  = 33'sd20861;
    localparam logic signed [44:0] PI_Q16      = 45'sd205887;
    localparam logic signed [45:0] INV_1P3_Q16 = 46'sd50412;

    // taylor series divisors (2n)(2n+1)
    localparam int unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

    typedef struct packed {
        logic [14:0] h;
        logic [15:0] it;
    } cfg_t;

    typedef struct packed {
        logic               contact;
        logic [15:0]        phase;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
        logic signed [15:0] vel_x;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_z;
    } res_t;

    // sin(pi/2 * k / 2^qbits) in q15, evaluated at elaboration
    function automatic logic [15:0] quarter_sine(input logic [31:0] k,
                                                 input int unsigned qbits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] r;
        x    = (64'(k) * HALF_PI_Q30) >> qbits;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++)
        begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'(TAYLOR_DIV[n]);
            if ((n & 1) != 0)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        r = (sum + 64'sd16384) >>> 15;
        if (r < 64'sd0)
            r = 64'sd0;
        if (r > 64'sd32768)
            r = 64'sd32768;
        return r[15:0];
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767)
            return 16'sh7fff;
        else if (v < -32'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/cycloid_swing_foot_trajectory.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// cycloid_swing_foot_trajectory
// per-leg cycloid swing foot position and velocity generator
// ----------------------------------------------------------------------------
// usage
//   one input item per leg on the s_ stream: tuser carries the contact flag,
//   tdata the swing phase and the start and touchdown positions
//   one result item per input item on the m_ stream: position and velocity
//   of the foot, all q4.12, saturated to 16 bits
//   stance items echo the start position with zero velocity
//   step height and inverse swing time come from the cfg write port; write
//   them only while no item is in flight
// throughput
//   one item per cycle sustained while m_tready stays high; an accepted
//   item passes in order through the six register stages of the datapath
//   (lookup, phase term, products, position sum, velocity scale, round and
//   saturate), and m_tvalid rises once it holds the last stage
// reset
//   rst_n clears all stage valid bits and loads the register defaults
//   (step height 328, inverse swing time 512)
// stall
//   when m_tready is low the result holds; empty stages behind it still
//   fill, and s_tready falls only once all six stages hold an item
// ----------------------------------------------------------------------------
module cycloid_swing_foot_trajectory #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // configuration write port
    input  wire logic                            cfg_we,
    input  wire logic [csft_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [csft_pkg::CFG_DATA_W-1:0]  cfg_data,
    // input stream
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // phase, start_x, start_y, start_z, end_x, end_y (16 bits each)
    input  wire logic [95:0]                     s_tdata,
    // in_contact
    input  wire logic [0:0]                      s_tuser,
    // output stream
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (16 bits each)
    output logic [95:0]                          m_tdata
);

    logic [14:0] step_height_reg;
    logic [15:0] inv_swing_time_reg;

    csft_pkg::cfg_t     cfg;
    csft_pkg::in_item_t in_item;
    csft_pkg::res_t     res;

    // configuration registers, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_height_reg    <= 15'd328;
            inv_swing_time_reg <= 16'd512;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                csft_pkg::REG_STEP_HEIGHT:    step_height_reg    <= cfg_data[14:0];
                csft_pkg::REG_INV_SWING_TIME: inv_swing_time_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg.h  = step_height_reg;
    assign cfg.it = inv_swing_time_reg;

    // unpack the input item
    assign in_item.contact = s_tuser[0];
    assign in_item.phase   = s_tdata[15:0];
    assign in_item.sx      = $signed(s_tdata[31:16]);
    assign in_item.sy      = $signed(s_tdata[47:32]);
    assign in_item.sz      = $signed(s_tdata[63:48]);
    assign in_item.ex      = $signed(s_tdata[79:64]);
    assign in_item.ey      = $signed(s_tdata[95:80]);

    csft_pipe #(
        .SINE_ADDR_BITS(SINE_ADDR_BITS)
    ) u_pipe (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (res)
    );

    // pack the result item, first field in the lowest bits
    assign m_tdata = {res.vel_z, res.vel_y, res.vel_x, res.pos_z, res.pos_y, res.pos_x};

endmodule
`default_nettype wire

@@ hw/rtl/csft_sine_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csft_sine_rom
// quarter-wave sine table, gives sine and cosine of one table address
// ----------------------------------------------------------------------------
module csft_sine_rom #(
    parameter int ADDR_BITS = 10
) (
    input  wire logic [ADDR_BITS-1:0] addr,
    output logic signed [16:0]        sin_val,
    output logic signed [16:0]        cos_val
);

    localparam int QBITS   = ADDR_BITS - 2;
    localparam int QUARTER = 1 << QBITS;
    localparam int IDXW    = QBITS + 1;

    function automatic logic [QUARTER:0][15:0] build_qtab();
        logic [QUARTER:0][15:0] t;
        for (int k = 0; k <= QUARTER; k++)
            t[k] = csft_pkg::quarter_sine(32'(k), QBITS);
        return t;
    endfunction

    localparam logic [QUARTER:0][15:0] QTAB = build_qtab();

    logic [1:0]        quad;
    logic [IDXW-1:0]   fwd_idx;
    logic [IDXW-1:0]   rev_idx;
    logic signed [16:0] fwd_val;
    logic signed [16:0] rev_val;

    assign quad    = addr[ADDR_BITS-1 -: 2];
    assign fwd_idx = {1'b0, addr[QBITS-1:0]};
    assign rev_idx = IDXW'(QUARTER) - fwd_idx;
    assign fwd_val = $signed({1'b0, QTAB[fwd_idx]});
    assign rev_val = $signed({1'b0, QTAB[rev_idx]});

    // cosine sits one quadrant ahead of sine
    always_comb
    begin
        unique case (quad)
            2'd0:
            begin
                sin_val = fwd_val;
                cos_val = rev_val;
            end
            2'd1:
            begin
                sin_val = rev_val;
                cos_val = -fwd_val;
            end
            2'd2:
            begin
                sin_val = -fwd_val;
                cos_val = -rev_val;
            end
            default:
            begin
                sin_val = -rev_val;
                cos_val = fwd_val;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ hw/rtl/csft_pipe.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// csft_pipe
// six-stage trajectory datapath with per-stage valid and ready
// ----------------------------------------------------------------------------
module csft_pipe #(
    parameter int SINE_ADDR_BITS = 10
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire csft_pkg::cfg_t     cfg,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire csft_pkg::in_item_t in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output csft_pkg::res_t          out_res
);

    typedef struct packed {
        logic               contact;
        logic [15:0]        phase;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [16:0] s;
        logic signed [16:0] c;
    } st1_t;

    typedef struct packed {
        logic               contact;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic signed [17:0] frac;
        logic signed [17:0] omc;
        logic signed [31:0] hs;
    } st2_t;

    typedef struct packed {
        logic               contact;
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [34:0] mx;
        logic signed [34:0] my;
        logic signed [33:0] hz;
        logic signed [34:0] dxo;
        logic signed [34:0] dyo;
        logic signed [25:0] hsi;
    } st3_t;

    typedef struct packed {
        logic               contact;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [28:0] vxr;
        logic signed [28:0] vyr;
        logic signed [28:0] vzr;
    } st4_t;

    typedef struct packed {
        logic               contact;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic signed [15:0] pz;
        logic signed [45:0] vxp;
        logic signed [45:0] vyp;
        logic signed [45:0] vzp;
    } st5_t;

    typedef struct packed {
        logic           contact;
        csft_pkg::res_t res;
    } st6_t;

    logic [6:1] v_reg;
    logic [7:1] rdy;

    st1_t st1_reg, st1_next;
    st2_t st2_reg, st2_next;
    st3_t st3_reg, st3_next;
    st4_t st4_reg, st4_next;
    st5_t st5_reg, st5_next;
    st6_t st6_reg, st6_next;

    logic signed [16:0] rom_sin;
    logic signed [16:0] rom_cos;
    logic signed [15:0] h_s;
    logic signed [16:0] it_s;

    assign h_s  = $signed({1'b0, cfg.h});
    assign it_s = $signed({1'b0, cfg.it});

    // a stage takes new data when it is empty or its successor moves
    always_comb
    begin
        rdy[7] = out_ready;
        for (int k = 6; k >= 1; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign in_ready  = rdy[1];
    assign out_valid = v_reg[6];
    assign out_res   = st6_reg.res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (rdy[1]) v_reg[1] <= in_valid;
            if (rdy[2]) v_reg[2] <= v_reg[1];
            if (rdy[3]) v_reg[3] <= v_reg[2];
            if (rdy[4]) v_reg[4] <= v_reg[3];
            if (rdy[5]) v_reg[5] <= v_reg[4];
            if (rdy[6]) v_reg[6] <= v_reg[5];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1] && in_valid) st1_reg <= st1_next;
        if (rdy[2] && v_reg[1]) st2_reg <= st2_next;
        if (rdy[3] && v_reg[2]) st3_reg <= st3_next;
        if (rdy[4] && v_reg[3]) st4_reg <= st4_next;
        if (rdy[5] && v_reg[4]) st5_reg <= st5_next;
        if (rdy[6] && v_reg[5]) st6_reg <= st6_next;
    end

    // stage 1: table lookup and displacement
    csft_sine_rom #(
        .ADDR_BITS(SINE_ADDR_BITS)
    ) u_rom (
        .addr    (in_item.phase[15 -: SINE_ADDR_BITS]),
        .sin_val (rom_sin),
        .cos_val (rom_cos)
    );

    always_comb
    begin
        st1_next.contact = in_item.contact;
        st1_next.phase   = in_item.phase;
        st1_next.sx      = in_item.sx;
        st1_next.sy      = in_item.sy;
        st1_next.sz      = in_item.sz;
        st1_next.dx      = 17'($signed(in_item.ex)) - 17'($signed(in_item.sx));
        st1_next.dy      = 17'($signed(in_item.ey)) - 17'($signed(in_item.sy));
        st1_next.s       = rom_sin;
        st1_next.c       = rom_cos;
    end

    // stage 2: cycloid phase term, one minus cosine, height times sine
    always_comb
    begin : s2_comb
        logic signed [32:0] sp;
        sp = 33'($signed(st1_reg.s)) * csft_pkg::INV_PI_Q16 + 33'sd32768;
        st2_next.contact = st1_reg.contact;
        st2_next.sx      = st1_reg.sx;
        st2_next.sy      = st1_reg.sy;
        st2_next.sz      = st1_reg.sz;
        st2_next.dx      = st1_reg.dx;
        st2_next.dy      = st1_reg.dy;
        st2_next.frac    = $signed({2'b00, st1_reg.phase}) - 18'($signed(sp[32:16]));
        st2_next.omc     = 18'sd32768 - 18'($signed(st1_reg.c));
        st2_next.hs      = 32'(h_s) * 32'($signed(st1_reg.s));
    end

    // stage 3: position products, velocity products, vertical rate
    always_comb
    begin : s3_comb
        logic signed [48:0] hp;
        hp = 49'($signed(st2_reg.hs)) * 49'(it_s) + 49'sd4194304;
        st3_next.contact = st2_reg.contact;
        st3_next.sx      = st2_reg.sx;
        st3_next.sy      = st2_reg.sy;
        st3_next.sz      = st2_reg.sz;
        st3_next.mx      = 35'($signed(st2_reg.dx)) * 35'($signed(st2_reg.frac));
        st3_next.my      = 35'($signed(st2_reg.dy)) * 35'($signed(st2_reg.frac));
        st3_next.hz      = 34'(h_s) * 34'($signed(st2_reg.omc));
        st3_next.dxo     = 35'($signed(st2_reg.dx)) * 35'($signed(st2_reg.omc));
        st3_next.dyo     = 35'($signed(st2_reg.dy)) * 35'($signed(st2_reg.omc));
        st3_next.hsi     = $signed(hp[48:23]);
    end

    // stage 4: final positions, horizontal rates, vertical rate times pi
    always_comb
    begin : s4_comb
        logic signed [34:0] rx;
        logic signed [34:0] ry;
        logic signed [33:0] rz;
        logic signed [19:0] ax;
        logic signed [19:0] ay;
        logic signed [18:0] az;
        logic signed [51:0] qx;
        logic signed [51:0] qy;
        logic signed [44:0] qz;
        rx = $signed(st3_reg.mx) + 35'sd32768;
        ry = $signed(st3_reg.my) + 35'sd32768;
        rz = $signed(st3_reg.hz) + 34'sd32768;
        ax = 20'($signed(st3_reg.sx)) + 20'($signed(rx[34:16]));
        ay = 20'($signed(st3_reg.sy)) + 20'($signed(ry[34:16]));
        az = 19'($signed(st3_reg.sz)) + 19'($signed(rz[33:16]));
        qx = 52'($signed(st3_reg.dxo)) * 52'(it_s) + 52'sd4194304;
        qy = 52'($signed(st3_reg.dyo)) * 52'(it_s) + 52'sd4194304;
        qz = 45'($signed(st3_reg.hsi)) * csft_pkg::PI_Q16 + 45'sd32768;
        st4_next.contact = st3_reg.contact;
        if (st3_reg.contact)
        begin
            st4_next.px = st3_reg.sx;
            st4_next.py = st3_reg.sy;
            st4_next.pz = st3_reg.sz;
        end
        else
        begin
            st4_next.px = csft_pkg::sat16(32'(ax));
            st4_next.py = csft_pkg::sat16(32'(ay));
            st4_next.pz = csft_pkg::sat16(32'(az));
        end
        st4_next.vxr = $signed(qx[51:23]);
        st4_next.vyr = $signed(qy[51:23]);
        st4_next.vzr = $signed(qz[44:16]);
    end

    // stage 5: 1/1.3 velocity scale
    always_comb
    begin
        st5_next.contact = st4_reg.contact;
        st5_next.px      = st4_reg.px;
        st5_next.py      = st4_reg.py;
        st5_next.pz      = st4_reg.pz;
        st5_next.vxp     = 46'($signed(st4_reg.vxr)) * csft_pkg::INV_1P3_Q16;
        st5_next.vyp     = 46'($signed(st4_reg.vyr)) * csft_pkg::INV_1P3_Q16;
        st5_next.vzp     = 46'($signed(st4_reg.vzr)) * csft_pkg::INV_1P3_Q16;
    end

    // stage 6: round, saturate, zero velocity in stance
    always_comb
    begin : s6_comb
        logic signed [45:0] wx;
        logic signed [45:0] wy;
        logic signed [45:0] wz;
        wx = $signed(st5_reg.vxp) + 46'sd32768;
        wy = $signed(st5_reg.vyp) + 46'sd32768;
        wz = $signed(st5_reg.vzp) + 46'sd32768;
        st6_next.contact   = st5_reg.contact;
        st6_next.res.pos_x = st5_reg.px;
        st6_next.res.pos_y = st5_reg.py;
        st6_next.res.pos_z = st5_reg.pz;
        if (st5_reg.contact)
        begin
            st6_next.res.vel_x = '0;
            st6_next.res.vel_y = '0;
            st6_next.res.vel_z = '0;
        end
        else
        begin
            st6_next.res.vel_x = csft_pkg::sat16(32'($signed(wx[45:16])));
            st6_next.res.vel_y = csft_pkg::sat16(32'($signed(wy[45:16])));
            st6_next.res.vel_z = csft_pkg::sat16(32'($signed(wz[45:16])));
        end
    end

`ifndef ASSERT_OFF
    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v_reg == 6'b111111))
        else $error("input blocked while a stage is empty");

    a_stage1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[1] && !rdy[2]) |=> (v_reg[1] && $stable(st1_reg)))
        else $error("stalled stage 1 item changed");

    a_omc_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[2] |-> !st2_reg.omc[17])
        else $error("one minus cosine went negative");

    a_stance_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[6] && st6_reg.contact) |->
        (st6_reg.res.vel_x == 16'sd0 && st6_reg.res.vel_y == 16'sd0 &&
         st6_reg.res.vel_z == 16'sd0))
        else $error("stance item with nonzero velocity");
`endif

endmodule
`default_nettype wire

@@ tb/tb_cycloid_swing_foot_trajectory.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cycloid_swing_foot_trajectory
// self-checking bench for the cycloid swing foot trajectory stream block
// ----------------------------------------------------------------------------
// a directed table of leg items is followed by random legs under several
// register settings (reset values, both extremes, zero swing rate, random);
// every accepted item is predicted by a bit-exact fixed-point model held
// here and checked field by field against the result stream, while both
// stream sides idle and stall in random bursts
// ----------------------------------------------------------------------------
module tb_cycloid_swing_foot_trajectory;

    localparam int SINE_BITS  = 10;
    localparam int ROM_DEPTH  = 1 << SINE_BITS;
    localparam int QUARTER    = ROM_DEPTH / 4;
    // six register stages from accept to result
    localparam int PIPE_DEPTH = 6;
    // receiver hold-off used to back the pipeline up to the input
    localparam int LONG_HOLD  = 60;
    localparam logic [15:0] PHASE_LSB_MASK = 16'((1 << (16 - SINE_BITS)) - 1);

    // register indexes with no register behind them
    localparam logic [1:0] REG_SPARE_LO = 2'd2;
    localparam logic [1:0] REG_SPARE_HI = 2'd3;

    // fixed-point constants of the trajectory math
    localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
    localparam longint RECIP_PI_Q16   = 20861;
    localparam longint PI_SCALE_Q16   = 205887;
    localparam longint VEL_DERATE_Q16 = 50412;

    typedef struct {
        csft_pkg::in_item_t leg;
        bit                 known;
        csft_pkg::res_t     want;
    } leg_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    // phase, start_x, start_y, start_z, end_x, end_y (16 bits each)
    logic [95:0] s_tdata;
    // in_contact
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (16 bits each)
    logic [95:0] m_tdata;

    // bench copy of the two registers
    logic [14:0] lift_h;
    logic [15:0] swing_rate;

    // full-period sine table in q1.15
    int          sine_q15 [ROM_DEPTH];

    // foot commands still owed by the block, oldest first
    csft_pkg::res_t due_cmds [$];
    int          fail_count;
    int          results_seen;

    bit          tx_gaps_on;
    bit          rx_stalls_on;
    bit          long_hold_req;

    // typed expectation that goes with the item currently offered
    bit             row_known;
    csft_pkg::res_t row_want;

    leg_row_t    stim_rows [20];
    string       field_names [6] = '{"pos_x", "pos_y", "pos_z", "vel_x", "vel_y", "vel_z"};

    cycloid_swing_foot_trajectory #(
        .SINE_ADDR_BITS (SINE_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // generous wall clock limit, far above the slowest legal run
    initial
    begin : watchdog
        #400000;
        $display("== FAIL ==");
        $finish;
    end

    // round half up: add half an lsb, then floor shift
    function automatic longint rnd_shift(input longint v, input int n);
        return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic logic [15:0] clip16(input longint v);
        if (v > 32767)
            return 16'h7fff;
        if (v < -32768)
            return 16'h8000;
        return v[15:0];
    endfunction

    // expected position and velocity of one leg under the current registers
    function automatic csft_pkg::res_t foot_command(input csft_pkg::in_item_t leg);
        csft_pkg::res_t cmd;
        int unsigned    addr;
        longint         s, c, frac, omc, h, it, sx, sy, sz, dx, dy, vz;
        sx = longint'($signed(leg.sx));
        sy = longint'($signed(leg.sy));
        sz = longint'($signed(leg.sz));
        if (leg.contact)
        begin
            // stance holds the start point and stands still
            cmd.pos_x = leg.sx;
            cmd.pos_y = leg.sy;
            cmd.pos_z = leg.sz;
            cmd.vel_x = '0;
            cmd.vel_y = '0;
            cmd.vel_z = '0;
            return cmd;
        end
        addr = int'(leg.phase) >> (16 - SINE_BITS);
        s    = sine_q15[addr];
        c    = sine_q15[(addr + QUARTER) % ROM_DEPTH];
        // cycloid progress: phase - sin / (2 pi), q0.16
        frac = longint'(leg.phase) - rnd_shift(s * RECIP_PI_Q16, 16);
        omc  = 32768 - c;
        h    = longint'(lift_h);
        it   = longint'(swing_rate);
        dx   = longint'($signed(leg.ex)) - sx;
        dy   = longint'($signed(leg.ey)) - sy;
        cmd.pos_x = clip16(sx + rnd_shift(dx * frac, 16));
        cmd.pos_y = clip16(sy + rnd_shift(dy * frac, 16));
        cmd.pos_z = clip16(sz + rnd_shift(h * omc, 16));
        cmd.vel_x = clip16(rnd_shift(rnd_shift(dx * omc * it, 23) * VEL_DERATE_Q16, 16));
        cmd.vel_y = clip16(rnd_shift(rnd_shift(dy * omc * it, 23) * VEL_DERATE_Q16, 16));
        vz        = rnd_shift(rnd_shift(h * s * it, 23) * PI_SCALE_Q16, 16);
        cmd.vel_z = clip16(rnd_shift(vz * VEL_DERATE_Q16, 16));
        return cmd;
    endfunction

    // sine table: quarter wave from a truncated q2.30 taylor series, then
    // mirrored and negated into the other three quadrants
    initial
    begin : build_sine
        int              quarter_tab [QUARTER + 1];
        longint unsigned ang;
        longint unsigned term;
        longint          acc;
        longint          q;
        for (int k = 0; k <= QUARTER; k++)
        begin
            ang  = (64'(k) * QUARTER_TURN_Q30) >> (SINE_BITS - 2);
            term = ang;
            acc  = longint'(ang);
            for (int n = 1; n <= 7; n++)
            begin
                term = (term * ang) >> 30;
                term = (term * ang) >> 30;
                term = term / 64'((2 * n) * (2 * n + 1));
                if (n % 2 == 1)
                    acc = acc - longint'(term);
                else
                    acc = acc + longint'(term);
            end
            q = rnd_shift(acc, 15);
            if (q < 0)
                q = 0;
            if (q > 32768)
                q = 32768;
            quarter_tab[k] = int'(q);
        end
        for (int a = 0; a < ROM_DEPTH; a++)
        begin
            unique case (a / QUARTER)
                0:       sine_q15[a] = quarter_tab[a % QUARTER];
                1:       sine_q15[a] = quarter_tab[QUARTER - a % QUARTER];
                2:       sine_q15[a] = -quarter_tab[a % QUARTER];
                default: sine_q15[a] = -quarter_tab[QUARTER - a % QUARTER];
            endcase
        end
    end

    // coordinates: half leg-sized, some extremes, the rest full range
    function automatic logic [15:0] rand_coord();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return 16'h7fff;
        if (pick < 8)
            return 16'h8000;
        if (pick < 10)
            return 16'h0000;
        if (pick < 60)
            return 16'($urandom_range(0, 8191)) - 16'd4096;
        return 16'($urandom);
    endfunction

    // phases: quadrant edges, table address edges, the top value, anything
    function automatic logic [15:0] rand_phase();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'($urandom_range(0, 3)) << 14;
        if (pick < 20)
            return (16'($urandom_range(0, ROM_DEPTH - 1)) << (16 - SINE_BITS))
                   | ($urandom_range(0, 1) ? PHASE_LSB_MASK : 16'h0000);
        if (pick < 24)
            return 16'hffff;
        return 16'($urandom);
    endfunction

    function automatic csft_pkg::in_item_t rand_leg();
        csft_pkg::in_item_t leg;
        leg.contact = ($urandom_range(0, 99) < 25);
        leg.phase   = rand_phase();
        leg.sx      = rand_coord();
        leg.sy      = rand_coord();
        leg.sz      = rand_coord();
        leg.ex      = rand_coord();
        leg.ey      = rand_coord();
        return leg;
    endfunction

    // offer one leg item from a falling edge and hold it until accepted
    task automatic send_leg(input csft_pkg::in_item_t leg, input bit known,
                            input csft_pkg::res_t want);
        s_tdata   <= {leg.ey, leg.ex, leg.sz, leg.sy, leg.sx, leg.phase};
        s_tuser   <= leg.contact;
        s_tvalid  <= 1'b1;
        row_known = known;
        row_want  = want;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        // sender gap burst
        if (tx_gaps_on && $urandom_range(0, 99) < 12)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
    endtask

    task automatic run_random(input int count);
        for (int i = 0; i < count; i++)
            send_leg(rand_leg(), 1'b0, '0);
    endtask

    // stop offering and let every owed result come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (due_cmds.size() != 0)
            @(negedge clk);
        repeat (PIPE_DEPTH + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
        // only the register width is kept, spare indexes change nothing
        if (index == csft_pkg::REG_STEP_HEIGHT)
            lift_h = value[14:0];
        else if (index == csft_pkg::REG_INV_SWING_TIME)
            swing_rate = value;
    endtask

    // result side: random stall bursts, plus one long hold on request
    initial
    begin : result_sink
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (int n = 0; n < LONG_HOLD; n++)
                    @(negedge clk);
                m_tready <= 1'b1;
            end
            else if (rx_stalls_on && $urandom_range(0, 99) < 12)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // both handshakes sampled at the rising edge: results are checked first,
    // then an accepted item queues its expected foot command
    initial
    begin : watch_streams
        csft_pkg::res_t     want;
        csft_pkg::in_item_t leg;
        logic [15:0]        want_f [6];
        logic [15:0]        got_f [6];
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (m_tvalid && m_tready)
                begin
                    if (due_cmds.size() == 0)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result %0d with no item owed: %h", results_seen,
                                     m_tdata);
                    end
                    else
                    begin
                        want   = due_cmds.pop_front();
                        want_f = '{want.pos_x, want.pos_y, want.pos_z,
                                   want.vel_x, want.vel_y, want.vel_z};
                        for (int i = 0; i < 6; i++)
                            got_f[i] = m_tdata[16 * i +: 16];
                        for (int i = 0; i < 6; i++)
                        begin
                            if (got_f[i] !== want_f[i])
                            begin
                                fail_count++;
                                if (fail_count <= 10)
                                    $display("result %0d %0s: expected %h, got %h",
                                             results_seen, field_names[i], want_f[i],
                                             got_f[i]);
                            end
                        end
                    end
                    results_seen++;
                end
                if (s_tvalid && s_tready)
                begin
                    leg.contact = s_tuser[0];
                    leg.phase   = s_tdata[15:0];
                    leg.sx      = s_tdata[31:16];
                    leg.sy      = s_tdata[47:32];
                    leg.sz      = s_tdata[63:48];
                    leg.ex      = s_tdata[79:64];
                    leg.ey      = s_tdata[95:80];
                    due_cmds.push_back(row_known ? row_want : foot_command(leg));
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = csft_pkg::REG_STEP_HEIGHT;
        cfg_data      = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        lift_h        = 15'd328;
        swing_rate    = 16'd512;
        fail_count    = 0;
        results_seen  = 0;
        tx_gaps_on    = 1'b1;
        rx_stalls_on  = 1'b1;
        long_hold_req = 1'b0;
        row_known     = 1'b0;
        row_want      = '0;

        // leg fields: contact, phase, start x/y/z, end x/y
        stim_rows = '{
            // stance legs echo the start point with zero velocity
            '{'{1'b1, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
              '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}},
            '{'{1'b1, 16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000}, 1'b1,
              '{16'h7fff, 16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'h0000}},
            '{'{1'b1, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff}, 1'b1,
              '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000}},
            '{'{1'b1, 16'h1234, 16'h0a5a, 16'hf5a5, 16'h0800, 16'hffff, 16'h0001}, 1'b1,
              '{16'h0a5a, 16'hf5a5, 16'h0800, 16'h0000, 16'h0000, 16'h0000}},
            '{'{1'b1, 16'h8000, 16'h0123, 16'hfedc, 16'h7000, 16'h8000, 16'h7fff}, 1'b1,
              '{16'h0123, 16'hfedc, 16'h7000, 16'h0000, 16'h0000, 16'h0000}},
            // swing legs: quadrant edges, table address edges, widest spans
            '{'{1'b0, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b0, '0},
            '{'{1'b0, 16'h0000, 16'h0400, 16'hfc00, 16'h0100, 16'h0400, 16'hfc00}, 1'b0, '0},
            '{'{1'b0, 16'h4000, 16'h8000, 16'h8000, 16'h0000, 16'h7fff, 16'h7fff}, 1'b0, '0},
            '{'{1'b0, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000}, 1'b0, '0},
            '{'{1'b0, 16'hc000, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000}, 1'b0, '0},
            '{'{1'b0, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff}, 1'b0, '0},
            '{'{1'b0, 16'h2000, 16'h0000, 16'h0000, 16'h8000, 16'h1000, 16'hf000}, 1'b0, '0},
            '{'{1'b0, 16'h003f, 16'h0200, 16'h0200, 16'h0000, 16'h0a00, 16'hf600}, 1'b0, '0},
            '{'{1'b0, 16'h0040, 16'h0200, 16'h0200, 16'h0000, 16'h0a00, 16'hf600}, 1'b0, '0},
            '{'{1'b0, 16'h0001, 16'hf000, 16'h1000, 16'h0000, 16'h1000, 16'hf000}, 1'b0, '0},
            '{'{1'b0, 16'h6000, 16'h0400, 16'hfc00, 16'hf000, 16'h0800, 16'hfe00}, 1'b0, '0},
            '{'{1'b0, 16'h7fff, 16'h0400, 16'hfc00, 16'hf000, 16'h0800, 16'hfe00}, 1'b0, '0},
            '{'{1'b0, 16'h8001, 16'h0400, 16'hfc00, 16'hf000, 16'h0800, 16'hfe00}, 1'b0, '0},
            '{'{1'b0, 16'ha000, 16'hfc00, 16'h0400, 16'h0800, 16'h0c00, 16'hf400}, 1'b0, '0},
            '{'{1'b0, 16'he000, 16'hffff, 16'hffff, 16'hffff, 16'h0001, 16'h0001}, 1'b0, '0}
        };

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed legs under the reset register values
        foreach (stim_rows[i])
            send_leg(stim_rows[i].leg, stim_rows[i].known, stim_rows[i].want);
        run_random(50);

        // receiver holds off while the sender keeps offering back to back,
        // so the pipeline fills and s_tready has to fall
        tx_gaps_on    = 1'b0;
        long_hold_req = 1'b1;
        for (int i = 0; i < 30; i++)
            send_leg(rand_leg(), 1'b0, '0);
        tx_gaps_on = 1'b1;

        // sender pauses until every owed result is back
        wait_drained();
        run_random(40);
        wait_drained();

        // largest lift, fastest swing
        write_reg(csft_pkg::REG_STEP_HEIGHT, 16'h7fff);
        write_reg(csft_pkg::REG_INV_SWING_TIME, 16'hffff);
        run_random(120);
        wait_drained();

        // no lift, slowest nonzero swing
        write_reg(csft_pkg::REG_STEP_HEIGHT, 16'h0000);
        write_reg(csft_pkg::REG_INV_SWING_TIME, 16'h0001);
        run_random(100);
        wait_drained();

        // oversize lift keeps its low 15 bits, zero swing rate gives zero
        // velocity, writes to spare indexes leave both registers alone
        write_reg(csft_pkg::REG_STEP_HEIGHT, 16'hffff);
        write_reg(csft_pkg::REG_INV_SWING_TIME, 16'h0000);
        write_reg(REG_SPARE_LO, 16'h1234);
        write_reg(REG_SPARE_HI, 16'hffff);
        run_random(100);
        wait_drained();

        write_reg(csft_pkg::REG_STEP_HEIGHT, 16'($urandom));
        write_reg(csft_pkg::REG_INV_SWING_TIME, 16'($urandom_range(1, 65535)));
        run_random(100);
        wait_drained();

        // closing stretch at full rate, no idling on either side
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        write_reg(csft_pkg::REG_STEP_HEIGHT, 16'($urandom_range(0, 4095)));
        write_reg(csft_pkg::REG_INV_SWING_TIME, 16'($urandom_range(256, 4096)));
        run_random(130);
        wait_drained();

        if (fail_count == 0 && due_cmds.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/csft_pkg.sv
hw/rtl/csft_sine_rom.sv
hw/rtl/csft_pipe.sv
hw/rtl/cycloid_swing_foot_trajectory.sv
tb/tb_cycloid_swing_foot_trajectory.sv
